### hdl/sct_pkg.sv
// Package for the S-expression character tokenizer.
// Holds result kinds, character codes, lexer modes and the plan word type.
// No dependencies.
`default_nettype none

package sct_pkg;

   localparam int unsigned CHAR_W = 8;
   localparam int unsigned KIND_W = 2;
   localparam int unsigned MAX_RESULTS = 3;

   localparam logic [KIND_W-1:0] KIND_CHAR       = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END_TOKEN  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END_SOURCE = 2'd2;

   localparam logic [1:0] MODE_NORMAL  = 2'd0;
   localparam logic [1:0] MODE_COMMENT = 2'd1;
   localparam logic [1:0] MODE_STRING  = 2'd2;

   localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
   localparam logic [CHAR_W-1:0] CH_HASH      = 8'h23;
   localparam logic [CHAR_W-1:0] CH_SEMI      = 8'h3B;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_OPEN      = 8'h28;
   localparam logic [CHAR_W-1:0] CH_CLOSE     = 8'h29;
   localparam logic [CHAR_W-1:0] CH_QUOTE     = 8'h22;
   localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;

   // One accepted character expands into a plan of zero to three results.
   typedef struct packed {
      logic [1:0]        count;
      logic [KIND_W-1:0] kind2;
      logic [KIND_W-1:0] kind1;
      logic [KIND_W-1:0] kind0;
      logic [CHAR_W-1:0] ch;
   } plan_type;

   typedef struct packed {
      logic     push;
      plan_type plan;
   } push_type;

   typedef struct packed {
      logic     empty;
      logic     full;
      plan_type head;
   } queue_status_type;

endpackage

`default_nettype wire

### hdl/sct_front.sv
// Front end of the tokenizer: accepts characters, keeps the lexer state
// and turns each character into a plan of results. Uses sct_pkg.
`default_nettype none

module sct_front import sct_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [CHAR_W-1:0] req_src_char,
   input  wire logic              req_abort,
   input  wire logic              queue_full,
   output push_type               push
);

   logic       in_token_ff, in_token_in;
   logic [1:0] lex_mode_ff, lex_mode_in;
   logic       after_backslash_ff, after_backslash_in;
   logic       accept;
   plan_type   plan;
   logic [CHAR_W-1:0] c;

   assign req_stall = queue_full;
   assign accept = req_valid && !queue_full;
   assign c = req_src_char;

   always_comb begin
      plan = '0;
      plan.ch = c;
      in_token_in = in_token_ff;
      lex_mode_in = lex_mode_ff;
      after_backslash_in = after_backslash_ff;
      priority if (req_abort) begin
         plan.count = 2'd1;
         plan.kind0 = KIND_END_SOURCE;
         in_token_in = 1'b0;
         lex_mode_in = MODE_NORMAL;
         after_backslash_in = 1'b0;
      end else if (lex_mode_ff == MODE_STRING) begin
         if (c == CH_NUL) begin
            plan.count = 2'd2;
            plan.kind0 = KIND_END_TOKEN;
            plan.kind1 = KIND_END_SOURCE;
            in_token_in = 1'b0;
            lex_mode_in = MODE_NORMAL;
            after_backslash_in = 1'b0;
         end else if (c == CH_QUOTE && !after_backslash_ff) begin
            plan.count = 2'd2;
            plan.kind0 = KIND_CHAR;
            plan.kind1 = KIND_END_TOKEN;
            in_token_in = 1'b0;
            lex_mode_in = MODE_NORMAL;
            after_backslash_in = 1'b0;
         end else begin
            plan.count = 2'd1;
            plan.kind0 = KIND_CHAR;
            after_backslash_in = (c == CH_BACKSLASH);
         end
      end else if (c == CH_NUL) begin
         plan.count = 2'd1;
         plan.kind0 = KIND_END_SOURCE;
         in_token_in = 1'b0;
         lex_mode_in = MODE_NORMAL;
         after_backslash_in = 1'b0;
      end else if (lex_mode_ff == MODE_COMMENT) begin
         if (c == CH_NEWLINE) begin
            lex_mode_in = MODE_NORMAL;
         end
      end else if (c == CH_HASH || c == CH_SEMI) begin
         lex_mode_in = MODE_COMMENT;
      end else if (c == CH_SPACE || c == CH_NEWLINE || c == CH_TAB) begin
         if (in_token_ff) begin
            plan.count = 2'd1;
            plan.kind0 = KIND_END_TOKEN;
            in_token_in = 1'b0;
         end
      end else if (c == CH_OPEN || c == CH_CLOSE) begin
         if (in_token_ff) begin
            plan.count = 2'd3;
            plan.kind0 = KIND_END_TOKEN;
            plan.kind1 = KIND_CHAR;
            plan.kind2 = KIND_END_TOKEN;
         end else begin
            plan.count = 2'd2;
            plan.kind0 = KIND_CHAR;
            plan.kind1 = KIND_END_TOKEN;
         end
         in_token_in = 1'b0;
      end else if (c == CH_QUOTE) begin
         if (in_token_ff) begin
            plan.count = 2'd2;
            plan.kind0 = KIND_END_TOKEN;
            plan.kind1 = KIND_CHAR;
         end else begin
            plan.count = 2'd1;
            plan.kind0 = KIND_CHAR;
         end
         in_token_in = 1'b1;
         lex_mode_in = MODE_STRING;
         after_backslash_in = 1'b0;
      end else begin
         plan.count = 2'd1;
         plan.kind0 = KIND_CHAR;
         in_token_in = 1'b1;
         lex_mode_in = MODE_NORMAL;
      end
   end

   assign push.push = accept && (plan.count != 2'd0);
   assign push.plan = plan;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_token_ff <= 1'b0;
         lex_mode_ff <= MODE_NORMAL;
         after_backslash_ff <= 1'b0;
      end else if (accept) begin
         in_token_ff <= in_token_in;
         lex_mode_ff <= lex_mode_in;
         after_backslash_ff <= after_backslash_in;
      end
   end

endmodule

`default_nettype wire

### hdl/sct_queue.sv
// Small queue of result plans between the tokenizer front and back ends.
// Uses sct_pkg for the plan type.
`default_nettype none

module sct_queue import sct_pkg::*; #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  push_type        push,
   input  wire logic       pop,
   output queue_status_type status
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   plan_type             store_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]     count_ff;
   logic                 do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.head  = store_ff[rd_ptr_ff];
   assign do_push = push.push && !status.full;
   assign do_pop  = pop && !status.empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push.plan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

### hdl/sct_back.sv
// Back end of the tokenizer: unrolls each plan into one result word per
// cycle when not stalled into a registered output stage. Uses sct_pkg.
`default_nettype none

module sct_back import sct_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  queue_status_type       status,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [KIND_W-1:0]      rsp_kind,
   output logic [CHAR_W-1:0]      rsp_tok_char,
   output logic                   rsp_final_of_run
);

   logic              busy_ff;
   plan_type          cur_ff;
   logic [1:0]        idx_ff;
   logic              rsp_valid_ff;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [CHAR_W-1:0] rsp_tok_char_ff, rsp_tok_char_in;
   logic              rsp_final_ff, rsp_final_in;
   plan_type          src;
   logic [1:0]        sidx;
   logic              have, out_free, advance;

   assign src = busy_ff ? cur_ff : status.head;
   assign sidx = busy_ff ? idx_ff : 2'd0;
   assign have = busy_ff || !status.empty;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance = have && out_free;
   assign pop = advance && !busy_ff;

   always_comb begin
      unique case (sidx)
         2'd0: rsp_kind_in = src.kind0;
         2'd1: rsp_kind_in = src.kind1;
         2'd2: rsp_kind_in = src.kind2;
         default: rsp_kind_in = KIND_END_SOURCE;
      endcase
      rsp_tok_char_in = (rsp_kind_in == KIND_CHAR) ? src.ch : '0;
      rsp_final_in = (sidx == src.count - 2'd1);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cur_ff <= src;
         idx_ff <= sidx + 2'd1;
         rsp_kind_ff <= rsp_kind_in;
         rsp_tok_char_ff <= rsp_tok_char_in;
         rsp_final_ff <= rsp_final_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         busy_ff <= !rsp_final_in;
         rsp_valid_ff <= 1'b1;
      end else if (out_free) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_kind_ff;
   assign rsp_tok_char = rsp_tok_char_ff;
   assign rsp_final_of_run = rsp_final_ff;

endmodule

`default_nettype wire

### hdl/sexpr_char_tokenizer.sv
// Top level of the S-expression character tokenizer.
// Instantiates sct_front, sct_queue and sct_back; uses sct_pkg.
//
// The request channel takes one source character per word, with an abort
// flag; character zero marks the end of the source. The response channel
// carries one result per word: a token character, an end-of-token mark or
// an end-of-source mark, with a flag on the last result caused by a
// character. A character causes zero to three results.
// A character is accepted in the cycle it is offered unless the plan queue
// of QUEUE_DEPTH entries is full, so one character per cycle is sustained
// while each causes at most one result and the output is not stalled.
// The back end delivers one result per cycle unless the output stalls,
// so a character with two or three results takes the output for each of
// them in turn, and the queue absorbs the difference. An accepted
// character's plan is registered in the queue, then loaded into the output stage.
// While the receiver stalls, the output word holds and the queue fills;
// once it is full, req_stall is raised.
// Synchronous reset empties the queue and output stage and returns the
// lexer to normal mode outside any token.
`default_nettype none

module sexpr_char_tokenizer import sct_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [CHAR_W-1:0] req_src_char,
   input  wire logic              req_abort,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [KIND_W-1:0]      rsp_kind,
   output logic [CHAR_W-1:0]      rsp_tok_char,
   output logic                   rsp_final_of_run
);

   push_type         push;
   queue_status_type status;
   logic             pop;

   sct_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_src_char (req_src_char),
      .req_abort    (req_abort),
      .queue_full   (status.full),
      .push         (push)
   );

   sct_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .status (status)
   );

   sct_back u_back (
      .clock            (clock),
      .reset            (reset),
      .status           (status),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_tok_char     (rsp_tok_char),
      .rsp_final_of_run (rsp_final_of_run)
   );

endmodule

`default_nettype wire

### hdl/sct_checker.sv
// Port-level checker for the S-expression character tokenizer, bound to
// the top level. Uses sct_pkg for the result kinds.
`default_nettype none

module sct_checker import sct_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [KIND_W-1:0] rsp_kind,
   input wire logic [CHAR_W-1:0] rsp_tok_char,
   input wire logic              rsp_final_of_run
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_tok_char) && $stable(rsp_final_of_run))
      else $error("Stalled response word changed.");

   a_no_rsp_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("Response word valid right after reset.");

   a_mark_has_no_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_CHAR |-> rsp_tok_char == '0)
      else $error("End mark carries a character.");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind == KIND_CHAR || rsp_kind == KIND_END_TOKEN
         || rsp_kind == KIND_END_SOURCE)
      else $error("Response kind out of range.");

   a_end_source_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_END_SOURCE |-> rsp_final_of_run)
      else $error("End of source is not the last result of its character.");

endmodule

bind sexpr_char_tokenizer sct_checker u_sct_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_tok_char     (rsp_tok_char),
   .rsp_final_of_run (rsp_final_of_run)
);

`default_nettype wire
